// ----- rtl/core/behf_pkg.sv -----
// Shared types and constants of the barrier elision hazard filter.
// Depends on nothing; imported by the front, back and top level modules.
`default_nettype none

package behf_pkg;

	localparam logic [2:0] OP_MATMUL = 3'd0;
	localparam logic [2:0] OP_VECTOR = 3'd1;
	localparam logic [2:0] OP_XFER   = 3'd2;
	localparam logic [2:0] OP_SYNC   = 3'd3;
	localparam logic [2:0] OP_END    = 3'd5;

	localparam logic [2:0] KIND_MATMUL = 3'b001;
	localparam logic [2:0] KIND_VECTOR = 3'b010;
	localparam logic [2:0] KIND_XFER   = 3'b100;

	localparam logic [7:0] VEC_EXTRA_READ = 8'd1;
	localparam logic [7:0] XFER_WRITE     = 8'd0;
	localparam logic [7:0] XFER_READ      = 8'd1;

	typedef enum logic [1:0] {
		CLS_ACCESS,
		CLS_SYNC,
		CLS_OTHER,
		CLS_END
	} cls_t;

	typedef enum logic [1:0] {
		PH_NONE,
		PH_FRESH,
		PH_SEG
	} phase_t;

	typedef struct packed {
		cls_t       cls;
		logic [2:0] kind;
		logic       unk;
	} cmd_t;

	typedef struct packed {
		logic   take;
		logic   emit;
		logic   is_end;
		phase_t phase;
	} back_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/behf_fifo.sv -----
// Small register queue between the front and back parts of the filter.
// Generic in width and depth; depends on nothing else.
`default_nettype none

module behf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/behf_front.sv -----
// Front part: classifies each command and builds its read and write buffer masks.
// Depends on behf_pkg.
`default_nettype none

module behf_front
	import behf_pkg::*;
#(
	parameter int NUM_BUFFERS = 32
) (
	input  wire logic [2:0]         op,
	input  wire logic [7:0]         buf_a,
	input  wire logic [7:0]         buf_b,
	input  wire logic [7:0]         buf_c,
	input  wire logic [7:0]         sub,
	input  wire logic               known,
	output cmd_t                    cmd,
	output logic [NUM_BUFFERS-1:0]  rd_mask,
	output logic [NUM_BUFFERS-1:0]  wr_mask
);

	localparam logic [NUM_BUFFERS-1:0] MaskOne = NUM_BUFFERS'(1);
	localparam logic [7:0]             IdLimit = 8'(NUM_BUFFERS);

	logic                   ok_a;
	logic                   ok_b;
	logic                   ok_c;
	logic [NUM_BUFFERS-1:0] bit_a;
	logic [NUM_BUFFERS-1:0] bit_b;
	logic [NUM_BUFFERS-1:0] bit_c;
	logic                   bad_id;
	logic [NUM_BUFFERS-1:0] rd_raw;
	logic [NUM_BUFFERS-1:0] wr_raw;

	assign ok_a  = (buf_a < IdLimit);
	assign ok_b  = (buf_b < IdLimit);
	assign ok_c  = (buf_c < IdLimit);
	assign bit_a = MaskOne << buf_a;
	assign bit_b = MaskOne << buf_b;
	assign bit_c = MaskOne << buf_c;

	always_comb begin
		cmd.cls  = CLS_OTHER;
		cmd.kind = '0;
		bad_id   = 1'b0;
		rd_raw   = '0;
		wr_raw   = '0;
		unique case (op)
			OP_MATMUL: begin
				cmd.cls  = CLS_ACCESS;
				cmd.kind = KIND_MATMUL;
				bad_id   = !ok_a || !ok_b || !ok_c;
				rd_raw   = bit_a | bit_b;
				wr_raw   = bit_c;
			end
			OP_VECTOR: begin
				cmd.cls  = CLS_ACCESS;
				cmd.kind = KIND_VECTOR;
				bad_id   = !ok_a || ((sub == VEC_EXTRA_READ) && !ok_b);
				rd_raw   = bit_a | ((sub == VEC_EXTRA_READ) ? bit_b : '0);
				wr_raw   = bit_a;
			end
			OP_XFER: begin
				cmd.cls  = CLS_ACCESS;
				cmd.kind = KIND_XFER;
				if (sub == XFER_WRITE) begin
					bad_id = !ok_a;
					wr_raw = bit_a;
				end else if (sub == XFER_READ) begin
					bad_id = !ok_a;
					rd_raw = bit_a;
				end
			end
			OP_SYNC: begin
				cmd.cls = CLS_SYNC;
			end
			OP_END: begin
				cmd.cls = CLS_END;
			end
			default: begin
				cmd.cls = CLS_OTHER;
			end
		endcase
		cmd.unk = (cmd.cls == CLS_ACCESS) && (!known || bad_id);
		rd_mask = cmd.unk ? '0 : rd_raw;
		wr_mask = cmd.unk ? '0 : wr_raw;
	end

endmodule

`default_nettype wire

// ----- rtl/core/behf_back.sv -----
// Back part: keeps the segment summaries, decides each sync and holds the result register.
// Depends on behf_pkg.
`default_nettype none

module behf_back
	import behf_pkg::*;
#(
	parameter int NUM_BUFFERS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_empty,
	input  wire cmd_t                   cmd,
	input  wire logic [NUM_BUFFERS-1:0] rd_mask,
	input  wire logic [NUM_BUFFERS-1:0] wr_mask,
	output logic                        q_pop,
	output logic                        empty,
	input  wire logic                   pop,
	output logic                        keep,
	output logic [15:0]                 sync_number,
	output back_status_t                status
);

	logic [NUM_BUFFERS-1:0] before_rd_q;
	logic [NUM_BUFFERS-1:0] before_wr_q;
	logic [2:0]             before_kind_q;
	logic                   before_unk_q;
	logic [NUM_BUFFERS-1:0] after_rd_q;
	logic [NUM_BUFFERS-1:0] after_wr_q;
	logic [2:0]             after_kind_q;
	logic                   after_unk_q;
	logic [NUM_BUFFERS-1:0] first_rd_q;
	logic [NUM_BUFFERS-1:0] first_wr_q;
	phase_t                 phase_q;
	logic [15:0]            counter_q;
	logic                   out_vld_q;
	logic                   keep_q;
	logic [15:0]            num_q;

	logic can_out;
	logic take;
	logic hazard;
	logic seg_keep;
	logic emit;
	logic emit_keep;

	assign can_out     = !out_vld_q || pop;
	assign take        = !q_empty && can_out;
	assign q_pop       = take;
	assign empty       = !out_vld_q;
	assign keep        = keep_q;
	assign sync_number = num_q;

	assign hazard = (|(first_rd_q & before_wr_q)) ||
	                (|(first_wr_q & (before_rd_q | before_wr_q)));
	assign seg_keep = after_unk_q || before_unk_q || (|(before_kind_q & after_kind_q)) || hazard;

	always_comb begin
		emit      = 1'b0;
		emit_keep = 1'b0;
		unique case (cmd.cls)
			CLS_END: begin
				emit      = (phase_q != PH_NONE);
				emit_keep = (phase_q == PH_FRESH) ? 1'b1 : seg_keep;
			end
			CLS_SYNC: begin
				emit      = (phase_q != PH_NONE);
				emit_keep = (phase_q == PH_SEG) ? seg_keep : 1'b0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign status.take   = take;
	assign status.emit   = take && emit;
	assign status.is_end = (cmd.cls == CLS_END);
	assign status.phase  = phase_q;

	always_ff @(posedge clk) begin
		if (take && emit) begin
			keep_q <= emit_keep;
			num_q  <= counter_q - 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q     <= 1'b0;
			before_rd_q   <= '0;
			before_wr_q   <= '0;
			before_kind_q <= '0;
			before_unk_q  <= 1'b0;
			after_rd_q    <= '0;
			after_wr_q    <= '0;
			after_kind_q  <= '0;
			after_unk_q   <= 1'b0;
			first_rd_q    <= '0;
			first_wr_q    <= '0;
			phase_q       <= PH_NONE;
			counter_q     <= '0;
		end else begin
			if (can_out) begin
				out_vld_q <= take && emit;
			end
			if (take) begin
				unique case (cmd.cls)
					CLS_END: begin
						before_rd_q   <= '0;
						before_wr_q   <= '0;
						before_kind_q <= '0;
						before_unk_q  <= 1'b0;
						after_rd_q    <= '0;
						after_wr_q    <= '0;
						after_kind_q  <= '0;
						after_unk_q   <= 1'b0;
						first_rd_q    <= '0;
						first_wr_q    <= '0;
						phase_q       <= PH_NONE;
						counter_q     <= '0;
					end
					CLS_SYNC: begin
						if (phase_q == PH_SEG) begin
							if (seg_keep) begin
								before_rd_q   <= after_rd_q;
								before_wr_q   <= after_wr_q;
								before_kind_q <= after_kind_q;
								before_unk_q  <= after_unk_q;
							end else begin
								before_rd_q   <= before_rd_q | after_rd_q;
								before_wr_q   <= before_wr_q | after_wr_q;
								before_kind_q <= before_kind_q | after_kind_q;
								before_unk_q  <= before_unk_q | after_unk_q;
							end
							after_rd_q   <= '0;
							after_wr_q   <= '0;
							after_kind_q <= '0;
							after_unk_q  <= 1'b0;
							first_rd_q   <= '0;
							first_wr_q   <= '0;
						end
						phase_q   <= PH_FRESH;
						counter_q <= counter_q + 16'd1;
					end
					CLS_ACCESS: begin
						if (phase_q == PH_NONE) begin
							if (cmd.unk) begin
								before_unk_q <= 1'b1;
							end else begin
								before_rd_q   <= before_rd_q | rd_mask;
								before_wr_q   <= before_wr_q | wr_mask;
								before_kind_q <= before_kind_q | cmd.kind;
							end
						end else begin
							if (phase_q == PH_FRESH) begin
								first_rd_q <= rd_mask;
								first_wr_q <= wr_mask;
								phase_q    <= PH_SEG;
							end
							if (cmd.unk) begin
								after_unk_q <= 1'b1;
							end else begin
								after_rd_q   <= after_rd_q | rd_mask;
								after_wr_q   <= after_wr_q | wr_mask;
								after_kind_q <= after_kind_q | cmd.kind;
							end
						end
					end
					default: begin
						if (phase_q == PH_NONE) begin
							before_unk_q <= 1'b1;
						end else begin
							phase_q     <= PH_SEG;
							after_unk_q <= 1'b1;
						end
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/barrier_elision_hazard_filter.sv -----
// Top level of the barrier elision hazard filter: front classifier, command queue, back decider.
// Depends on behf_pkg, behf_front, behf_fifo and behf_back.
//
// Channel   Direction  Handshake           Payload
// command   in         push / full         op, buf_a, buf_b, buf_c, sub, known
// decision  out        empty / pop         keep, sync_number
//
// A request is classified in the cycle it is pushed and enters a short queue. The back part
// takes one queued request per cycle, so the sustained rate is one request per clock, and
// stalls only while its result register holds an untaken decision; the front keeps accepting
// until the queue fills. A decision reaches the result ports in the cycle after the back part
// takes the request closing its segment. Reset clears all segment state and the sync count.
`default_nettype none

module barrier_elision_hazard_filter
	import behf_pkg::*;
#(
	parameter int NUM_BUFFERS = 32,
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  op,
	input  wire logic [7:0]  buf_a,
	input  wire logic [7:0]  buf_b,
	input  wire logic [7:0]  buf_c,
	input  wire logic [7:0]  sub,
	input  wire logic        known,
	output logic             empty,
	input  wire logic        pop,
	output logic             keep,
	output logic [15:0]      sync_number
);

	localparam int QW = $bits(cmd_t) + 2 * NUM_BUFFERS;

	cmd_t                   f_cmd;
	logic [NUM_BUFFERS-1:0] f_rd;
	logic [NUM_BUFFERS-1:0] f_wr;
	cmd_t                   b_cmd;
	logic [NUM_BUFFERS-1:0] b_rd;
	logic [NUM_BUFFERS-1:0] b_wr;
	logic [QW-1:0]          q_out;
	logic                   q_empty;
	logic                   q_pop;
	back_status_t           status;

	behf_front #(
		.NUM_BUFFERS(NUM_BUFFERS)
	) u_front (
		.op     (op),
		.buf_a  (buf_a),
		.buf_b  (buf_b),
		.buf_c  (buf_c),
		.sub    (sub),
		.known  (known),
		.cmd    (f_cmd),
		.rd_mask(f_rd),
		.wr_mask(f_wr)
	);

	behf_fifo #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data({f_cmd, f_rd, f_wr}),
		.full   (full),
		.rd_en  (q_pop),
		.rd_data(q_out),
		.empty  (q_empty)
	);

	assign {b_cmd, b_rd, b_wr} = q_out;

	behf_back #(
		.NUM_BUFFERS(NUM_BUFFERS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.cmd        (b_cmd),
		.rd_mask    (b_rd),
		.wr_mask    (b_wr),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.keep       (keep),
		.sync_number(sync_number),
		.status     (status)
	);

	a_no_take_from_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !status.take)
		else $error("back part took a request from an empty queue");

	a_push_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !q_empty)
		else $error("accepted request did not reach the queue");

	a_end_clears_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(status.take && status.is_end) |=> (status.phase == PH_NONE))
		else $error("end of block left a sync pending");

	a_emit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		status.emit |=> !empty)
		else $error("decision was lost before reaching the result ports");

endmodule

`default_nettype wire

// ----- verif/barrier_elision_hazard_filter_test.sv -----
// Self-checking testbench for barrier_elision_hazard_filter: drives command requests through the
// push/full queue and checks every sync decision popped from the empty/pop result port.
// Depends on behf_pkg and the barrier_elision_hazard_filter RTL; needs no files or arguments.
`timescale 1ns / 1ps

module barrier_elision_hazard_filter_test;
	import behf_pkg::*;

	localparam int BUFFER_COUNT = 32;
	localparam logic [2:0] OP_OTHER = 3'd4;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_REQUESTS = 450;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [2:0]  op;
	logic [7:0]  buf_a;
	logic [7:0]  buf_b;
	logic [7:0]  buf_c;
	logic [7:0]  sub;
	logic        known;
	logic        empty;
	logic        pop;
	logic        keep;
	logic [15:0] sync_number;

	logic quiet;
	int   cycle_count;

	class sync_decision_board;
		typedef struct packed {
			logic        keep;
			logic [15:0] number;
		} decision_t;

		decision_t               pending_decisions[$];
		int                      fail_count;
		logic [BUFFER_COUNT-1:0] before_rd, before_wr, after_rd, after_wr, first_rd, first_wr;
		logic [2:0]              before_kinds, after_kinds;
		logic                    before_unk, after_unk;
		phase_t                  phase;
		logic [15:0]             sync_count;

		function new();
			fail_count = 0;
			clear();
		endfunction

		function void clear();
			before_rd = '0;
			before_wr = '0;
			after_rd = '0;
			after_wr = '0;
			first_rd = '0;
			first_wr = '0;
			before_kinds = '0;
			after_kinds = '0;
			before_unk = 1'b0;
			after_unk = 1'b0;
			phase = PH_NONE;
			sync_count = '0;
		endfunction

		task report(string what);
			fail_count++;
			if (fail_count <= 100) begin
				$display("MISMATCH at cycle %0d: %s", cycle_count, what);
			end
		endtask

		function void add_decision(logic keep_it);
			decision_t d;
			d.keep = keep_it;
			d.number = sync_count - 16'd1;
			pending_decisions = {pending_decisions, d};
		endfunction

		// Decides the pending sync and folds the closed segment into the view since the
		// last kept barrier.
		function void close_segment();
			logic keep_it;
			logic hazard;
			if (phase == PH_FRESH) begin
				keep_it = 1'b1;
			end else begin
				hazard = |(first_rd & before_wr) || |(first_wr & (before_rd | before_wr));
				keep_it = after_unk || before_unk || |(before_kinds & after_kinds) || hazard;
			end
			add_decision(keep_it);
			if (keep_it) begin
				before_rd = after_rd;
				before_wr = after_wr;
				before_kinds = after_kinds;
				before_unk = after_unk;
			end else begin
				before_rd |= after_rd;
				before_wr |= after_wr;
				before_kinds |= after_kinds;
				before_unk |= after_unk;
			end
			after_rd = '0;
			after_wr = '0;
			after_kinds = '0;
			after_unk = 1'b0;
			first_rd = '0;
			first_wr = '0;
			phase = PH_NONE;
		endfunction

		function logic [BUFFER_COUNT-1:0] id_mask(logic [7:0] id);
			return {{(BUFFER_COUNT-1){1'b0}}, 1'b1} << id;
		endfunction

		function void summarize(logic [2:0] o, logic [7:0] a, logic [7:0] b, logic [7:0] c,
				logic [7:0] s, logic k, output logic [BUFFER_COUNT-1:0] rd,
				output logic [BUFFER_COUNT-1:0] wr, output logic [2:0] kind, output logic unk);
			rd = '0;
			wr = '0;
			unk = !k;
			if (o == OP_MATMUL) begin
				kind = KIND_MATMUL;
				if (a >= BUFFER_COUNT || b >= BUFFER_COUNT || c >= BUFFER_COUNT) begin
					unk = 1'b1;
				end else begin
					rd = id_mask(a) | id_mask(b);
					wr = id_mask(c);
				end
			end else if (o == OP_VECTOR) begin
				kind = KIND_VECTOR;
				if (a >= BUFFER_COUNT || (s == VEC_EXTRA_READ && b >= BUFFER_COUNT)) begin
					unk = 1'b1;
				end else begin
					rd = id_mask(a);
					wr = id_mask(a);
					if (s == VEC_EXTRA_READ) begin
						rd |= id_mask(b);
					end
				end
			end else begin
				kind = KIND_XFER;
				if (s == XFER_WRITE || s == XFER_READ) begin
					if (a >= BUFFER_COUNT) begin
						unk = 1'b1;
					end else if (s == XFER_WRITE) begin
						wr = id_mask(a);
					end else begin
						rd = id_mask(a);
					end
				end
			end
			if (unk) begin
				rd = '0;
				wr = '0;
			end
		endfunction

		function void note_command(logic [2:0] o, logic [7:0] a, logic [7:0] b, logic [7:0] c,
				logic [7:0] s, logic k);
			logic [BUFFER_COUNT-1:0] rd, wr;
			logic [2:0]              kind;
			logic                    unk;
			if (o == OP_END) begin
				if (phase != PH_NONE) begin
					close_segment();
				end
				clear();
			end else if (o == OP_SYNC) begin
				if (phase == PH_FRESH) begin
					add_decision(1'b0);
				end else if (phase == PH_SEG) begin
					close_segment();
				end
				phase = PH_FRESH;
				sync_count++;
			end else if (o == OP_MATMUL || o == OP_VECTOR || o == OP_XFER) begin
				summarize(o, a, b, c, s, k, rd, wr, kind, unk);
				if (phase == PH_NONE) begin
					if (unk) begin
						before_unk = 1'b1;
					end else begin
						before_rd |= rd;
						before_wr |= wr;
						before_kinds |= kind;
					end
				end else begin
					if (phase == PH_FRESH) begin
						first_rd = rd;
						first_wr = wr;
						phase = PH_SEG;
					end
					if (unk) begin
						after_unk = 1'b1;
					end else begin
						after_rd |= rd;
						after_wr |= wr;
						after_kinds |= kind;
					end
				end
			end else if (phase == PH_NONE) begin
				before_unk = 1'b1;
			end else begin
				phase = PH_SEG;
				after_unk = 1'b1;
			end
		endfunction

		task check_decision(logic got_keep, logic [15:0] got_number);
			decision_t d;
			if (pending_decisions.size() == 0) begin
				report($sformatf("decision keep=%0d sync=%0d with none outstanding",
					got_keep, got_number));
			end else begin
				d = pending_decisions.pop_front();
				if (got_keep !== d.keep) begin
					report($sformatf("sync %0d keep=%0d, predicted %0d", d.number, got_keep,
						d.keep));
				end
				if (got_number !== d.number) begin
					report($sformatf("sync_number=%0d, predicted %0d", got_number, d.number));
				end
			end
		endtask
	endclass

	sync_decision_board board;

	barrier_elision_hazard_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.op(op),
		.buf_a(buf_a),
		.buf_b(buf_b),
		.buf_c(buf_c),
		.sub(sub),
		.known(known),
		.empty(empty),
		.pop(pop),
		.keep(keep),
		.sync_number(sync_number)
	);

	always #10 clk = ~clk;

	task send_command(logic [2:0] o, logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] s,
			logic k);
		while (!quiet && $urandom_range(0, 99) < 31) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		op <= o;
		buf_a <= a;
		buf_b <= b;
		buf_c <= c;
		sub <= s;
		known <= k;
		do begin
			@(posedge clk);
		end while (full);
		board.note_command(o, a, b, c, s, k);
	endtask

	function logic [7:0] pick_id();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return 8'($urandom_range(0, 7));
		end else if (r < 95) begin
			return 8'($urandom_range(0, BUFFER_COUNT - 1));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task send_random_command();
		int         roll;
		logic [2:0] o;
		logic [7:0] s;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			send_command(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end else if (roll < 28) begin
			send_command(OP_SYNC, pick_id(), pick_id(), pick_id(), 8'($urandom_range(0, 255)),
				1'b1);
		end else if (roll < 33) begin
			case ($urandom_range(0, 2))
				0: o = OP_OTHER;
				1: o = 3'd6;
				default: o = 3'd7;
			endcase
			send_command(o, pick_id(), pick_id(), pick_id(), 8'($urandom_range(0, 255)), 1'b1);
		end else begin
			o = 3'($urandom_range(0, 2));
			s = 8'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(0, 255));
			send_command(o, pick_id(), pick_id(), pick_id(), s, $urandom_range(0, 99) < 96);
		end
	endtask

	task run_random(int count);
		int sent;
		int block_len;
		int k;
		sent = 0;
		while (sent < count) begin
			block_len = $urandom_range(1, 14);
			for (k = 0; k < block_len && sent < count; k++) begin
				quiet = (sent >= 150 && sent < 260);
				send_random_command();
				sent++;
			end
			if ($urandom_range(0, 99) < 85) begin
				send_command(OP_END, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
				sent++;
			end
		end
		quiet = 1'b0;
	endtask

	task run_directed();
		send_command(OP_MATMUL, 8'd0, 8'd31, 8'd1, 8'd0, 1'b1);
		send_command(OP_SYNC, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_command(OP_VECTOR, 8'd2, 8'd3, 8'd0, VEC_EXTRA_READ, 1'b1);
		send_command(OP_SYNC, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_command(OP_SYNC, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
		send_command(OP_XFER, 8'd1, 8'd0, 8'd0, XFER_READ, 1'b1);
		send_command(OP_OTHER, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_command(OP_SYNC, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_command(3'd6, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_command(OP_SYNC, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_command(3'd7, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_command(OP_SYNC, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_command(OP_END, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_command(OP_MATMUL, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
		send_command(OP_SYNC, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_command(OP_XFER, 8'd200, 8'd255, 8'd255, 8'd7, 1'b1);
		send_command(OP_SYNC, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_command(OP_VECTOR, 8'd5, 8'd255, 8'd255, 8'd0, 1'b1);
		send_command(OP_END, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_command(OP_XFER, 8'd4, 8'd0, 8'd0, XFER_WRITE, 1'b0);
		send_command(OP_SYNC, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_command(OP_END, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_command(OP_END, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_command(OP_XFER, 8'd31, 8'd0, 8'd0, XFER_WRITE, 1'b1);
		send_command(OP_SYNC, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send_command(OP_MATMUL, 8'd31, 8'd30, 8'd29, 8'd255, 1'b1);
		send_command(OP_END, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
	endtask

	initial begin
		clk = 1'b0;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		@(posedge clk);
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				board.check_decision(keep, sync_number);
			end
			pop <= !(!quiet && $urandom_range(0, 99) < 31);
		end
	end

	initial begin
		board = new();
		quiet = 1'b0;
		arst_n <= 1'b0;
		push <= 1'b0;
		pop <= 1'b0;
		op <= OP_MATMUL;
		buf_a <= '0;
		buf_b <= '0;
		buf_c <= '0;
		sub <= '0;
		known <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random(RANDOM_REQUESTS);
		push <= 1'b0;
		while (board.pending_decisions.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (board.fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
